// ===== src/qscp_pkg.sv =====
// Package with shared types, character codes and helpers of the query string command parser.
package qscp_pkg;

  typedef enum logic [1:0] {
    CV_SKIP,
    CV_POS,
    CV_NEG,
    CV_DONE
  } conv_phase_e;

  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChEq       = 8'h3D;
  localparam logic [7:0] ChPlus     = 8'h2B;
  localparam logic [7:0] ChMinus    = 8'h2D;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChNine     = 8'h39;

  localparam logic [31:0] MagLimit = 32'h8000_0000;
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;

  localparam int unsigned NumberW = 5;

  typedef struct packed {
    logic              cmd_valid;
    logic [7:0]        letter;
    logic [NumberW-1:0] number;
    logic [31:0]       key;
    logic              val_present;
    logic [31:0]       value;
    logic              end_of_query;
  } result_t;

  // Signed result of a conversion, given its magnitude and phase.
  function automatic logic [31:0] conv_final(logic [31:0] acc, conv_phase_e ph);
    logic [31:0] res;
    case (ph)
      CV_DONE: res = acc;
      CV_NEG:  res = 32'd0 - acc;
      CV_POS:  res = (acc > PosMax) ? PosMax : acc;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== src/qscp_conv.sv =====
// Decimal converter step: feeds one character into a saturating atoi accumulator.
module qscp_conv (
  input  logic [31:0]               acc_i,
  input  qscp_pkg::conv_phase_e     phase_i,
  input  logic [7:0]                char_i,
  output logic [31:0]               acc_o,
  output qscp_pkg::conv_phase_e     phase_o
);

  logic        is_digit;
  logic        is_space;
  logic [35:0] mul_sum;
  logic [31:0] acc_next;

  assign is_digit = (char_i >= qscp_pkg::ChZero) && (char_i <= qscp_pkg::ChNine);
  assign is_space = (char_i == qscp_pkg::ChSpace) ||
                    ((char_i >= qscp_pkg::ChTab) && (char_i <= qscp_pkg::ChCr));

  // The magnitude never exceeds 2^31, so ten times it plus a digit fits in 36 bits.
  assign mul_sum = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} +
                   {32'd0, char_i[3:0]};
  assign acc_next = (mul_sum > {4'd0, qscp_pkg::MagLimit}) ? qscp_pkg::MagLimit
                                                           : mul_sum[31:0];

  always_comb begin
    acc_o   = acc_i;
    phase_o = phase_i;
    case (phase_i)
      qscp_pkg::CV_SKIP: begin
        if (is_space) begin
          phase_o = qscp_pkg::CV_SKIP;
        end else if (char_i == qscp_pkg::ChPlus) begin
          phase_o = qscp_pkg::CV_POS;
        end else if (char_i == qscp_pkg::ChMinus) begin
          phase_o = qscp_pkg::CV_NEG;
        end else if (is_digit) begin
          acc_o   = acc_next;
          phase_o = qscp_pkg::CV_POS;
        end else begin
          acc_o   = 32'd0;
          phase_o = qscp_pkg::CV_DONE;
        end
      end
      qscp_pkg::CV_POS, qscp_pkg::CV_NEG: begin
        if (is_digit) begin
          acc_o = acc_next;
        end else begin
          acc_o   = qscp_pkg::conv_final(acc_i, phase_i);
          phase_o = qscp_pkg::CV_DONE;
        end
      end
      default: begin
        acc_o   = acc_i;
        phase_o = phase_i;
      end
    endcase
  end

endmodule

// ===== src/qscp_core.sv =====
// Parser state machine: tracks query phase, command count and both number conversions.
module qscp_core #(
  parameter int unsigned MaxCommands = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              last_i,
  output logic              has_result_o,
  output qscp_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(MaxCommands + 1);

  typedef enum logic [2:0] {
    PH_WAIT_Q,
    PH_LETTER,
    PH_KEY,
    PH_VALUE,
    PH_IGNORE
  } parse_phase_e;

  parse_phase_e          phase_q, phase_d, phase_n;
  logic [CntW-1:0]       seen_q, seen_d, seen_n;
  logic [7:0]            letter_q, letter_d, letter_n;
  logic [31:0]           key_q, key_d, key_n;
  qscp_pkg::conv_phase_e kph_q, kph_d, kph_n;
  logic [31:0]           val_q, val_d, val_n;
  qscp_pkg::conv_phase_e vph_q, vph_d, vph_n;
  logic                  vseen_q, vseen_d, vseen_n;

  logic [31:0]           key_fed, val_fed;
  qscp_pkg::conv_phase_e kph_fed, vph_fed;
  logic                  finished;
  logic [CntW+4:0]       seen_m1;

  qscp_conv u_key_conv (
    .acc_i   (key_q),
    .phase_i (kph_q),
    .char_i  (char_i),
    .acc_o   (key_fed),
    .phase_o (kph_fed)
  );

  qscp_conv u_val_conv (
    .acc_i   (val_q),
    .phase_i (vph_q),
    .char_i  (char_i),
    .acc_o   (val_fed),
    .phase_o (vph_fed)
  );

  always_comb begin
    phase_d  = phase_q;
    seen_d   = seen_q;
    letter_d = letter_q;
    key_d    = key_q;
    kph_d    = kph_q;
    val_d    = val_q;
    vph_d    = vph_q;
    vseen_d  = vseen_q;
    finished = 1'b0;
    case (phase_q)
      PH_WAIT_Q: begin
        if (char_i == qscp_pkg::ChQuestion) begin
          phase_d = PH_LETTER;
        end
      end
      PH_LETTER: begin
        if (seen_q >= CntW'(MaxCommands)) begin
          phase_d = PH_IGNORE;
        end else begin
          letter_d = char_i;
          seen_d   = seen_q + 1'b1;
          phase_d  = PH_KEY;
        end
      end
      PH_KEY: begin
        if (char_i == qscp_pkg::ChEq) begin
          vseen_d = 1'b1;
          phase_d = PH_VALUE;
        end else if (char_i == qscp_pkg::ChAmp) begin
          finished = 1'b1;
        end else begin
          key_d = key_fed;
          kph_d = kph_fed;
        end
      end
      PH_VALUE: begin
        if (char_i == qscp_pkg::ChAmp) begin
          finished = 1'b1;
        end else begin
          val_d = val_fed;
          vph_d = vph_fed;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
    if (last_i && ((phase_d == PH_KEY) || (phase_d == PH_VALUE))) begin
      finished = 1'b1;
    end
  end

  assign seen_m1 = {5'd0, seen_d} - 1'b1;

  always_comb begin
    result_o              = '0;
    result_o.end_of_query = last_i;
    if (finished) begin
      result_o.cmd_valid   = 1'b1;
      result_o.letter      = letter_d;
      result_o.number      = seen_m1[qscp_pkg::NumberW-1:0];
      result_o.key         = qscp_pkg::conv_final(key_d, kph_d);
      result_o.val_present = vseen_d;
      result_o.value       = qscp_pkg::conv_final(val_d, vph_d);
    end
  end

  assign has_result_o = finished || last_i;

  always_comb begin
    phase_n  = phase_d;
    seen_n   = seen_d;
    letter_n = letter_d;
    key_n    = key_d;
    kph_n    = kph_d;
    val_n    = val_d;
    vph_n    = vph_d;
    vseen_n  = vseen_d;
    if (finished || last_i) begin
      letter_n = 8'd0;
      key_n    = 32'd0;
      kph_n    = qscp_pkg::CV_SKIP;
      val_n    = 32'd0;
      vph_n    = qscp_pkg::CV_SKIP;
      vseen_n  = 1'b0;
      phase_n  = PH_LETTER;
    end
    if (last_i) begin
      phase_n = PH_WAIT_Q;
      seen_n  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT_Q;
      seen_q   <= '0;
      letter_q <= 8'd0;
      key_q    <= 32'd0;
      kph_q    <= qscp_pkg::CV_SKIP;
      val_q    <= 32'd0;
      vph_q    <= qscp_pkg::CV_SKIP;
      vseen_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_n;
      seen_q   <= seen_n;
      letter_q <= letter_n;
      key_q    <= key_n;
      kph_q    <= kph_n;
      val_q    <= val_n;
      vph_q    <= vph_n;
      vseen_q  <= vseen_n;
    end
  end

endmodule

// ===== src/query_string_command_parser.sv =====
// Top level of the query string command parser: input register, parser core, result register.
//
// The slave stream carries one character of a request string per request in
// s_axis_tdata; s_axis_tlast marks the final character of the string. Every
// character after the first '?' is parsed into commands of the form
// letter, key number, optional '=' value, separated by '&'.
// The master stream gives one result request per finished command, and one
// for the final character of every string, one request if both coincide;
// m_axis_tuser is 1 when the result holds a command and m_axis_tlast is 1 on
// the result of the final character. An accepted character passes through
// the input register and the parser core into the result register.
// Throughput is one character per cycle unless a result waits on a stalled
// receiver; the multiply by ten of both decimal converters is combinational.
// When the receiver stalls, the result register holds its request and the
// input register still drains characters that give no result; a character
// that gives a result waits until the result register frees up.
// Reset clears the parser to wait for '?' and empties both registers.
module query_string_command_parser #(
  parameter int unsigned MAX_COMMANDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] command_letter, [12:8] command_number, [44:13] key_number,
  // [45] value_present, [77:46] value_number, [79:78] zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,  // [0] command_valid
  output logic        m_axis_tlast
);

  logic              in_valid_q;
  logic [7:0]        in_char_q;
  logic              in_last_q;
  logic              out_valid_q;
  qscp_pkg::result_t out_q;
  qscp_pkg::result_t core_result;
  logic              core_has_result;
  logic              step;
  logic              load_out;

  assign step = in_valid_q && (!core_has_result || !out_valid_q || m_axis_tready);
  assign load_out = step && core_has_result;
  assign s_axis_tready = !in_valid_q || step;

  qscp_core #(
    .MaxCommands (MAX_COMMANDS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .char_i       (in_char_q),
    .last_i       (in_last_q),
    .has_result_o (core_has_result),
    .result_o     (core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.cmd_valid;
  assign m_axis_tlast  = out_q.end_of_query;
  assign m_axis_tdata  = {2'b00, out_q.value, out_q.val_present, out_q.key,
                          out_q.number, out_q.letter};

endmodule

// ===== src/qscp_checker.sv =====
// Port checker of the query string command parser, bound to the top level.
module qscp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result request keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result request changed while stalled");

  // A result without a command only comes from the final character.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("empty result not marked as end of query");

  // A result without a command carries all-zero fields.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 80'd0)
    else $error("empty result with nonzero fields");

  // Without an equals sign the value was never converted.
  a_no_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && !m_axis_tdata[45] |->
      m_axis_tdata[77:46] == 32'd0)
    else $error("value given without equals sign");

endmodule

bind query_string_command_parser qscp_checker u_qscp_checker (.*);

// ===== bench/query_string_command_parser_tb.sv =====
// Self-checking stream testbench for the query string command parser.
`timescale 1ns / 100ps

module query_string_command_parser_tb;

  localparam int unsigned MaxCommands = 32;
  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 200;
  localparam int HoldStart = 60;
  localparam int RandomChars = 1550;

  typedef enum logic [2:0] {
    P_WAIT_Q,
    P_LETTER,
    P_KEY,
    P_VALUE,
    P_IGNORE
  } query_phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  char_req_t           pending_chars[$];
  logic [7:0]          text[$];
  qscp_pkg::result_t   expected_results[$];

  // Parser state as the testbench sees it.
  query_phase_e          phase_q;
  logic [6:0]            cmds_q;
  logic [7:0]            letter_q;
  logic [31:0]           key_acc_q;
  qscp_pkg::conv_phase_e key_ph_q;
  logic [31:0]           val_acc_q;
  qscp_pkg::conv_phase_e val_ph_q;
  logic                  val_seen_q;

  int next_char = 0;
  int accepted_cnt = 0;
  int cycle_cnt = 0;
  int mismatches = 0;
  int results_seen = 0;
  int commands_seen = 0;
  int strings_built = 0;
  int limit_hits = 0;
  logic hold_on = 1'b0;
  logic hold_done = 1'b0;
  int   hold_count = 0;

  string edge_numbers[5] = '{"2147483647", "2147483648", "2147483649", "4294967296",
                             "99999999999"};

  query_string_command_parser #(
    .MAX_COMMANDS(MaxCommands)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] signed_number(logic [31:0] acc,
                                                qscp_pkg::conv_phase_e ph);
    logic [31:0] res;
    case (ph)
      qscp_pkg::CV_DONE: res = acc;
      qscp_pkg::CV_NEG:  res = 32'd0 - acc;
      qscp_pkg::CV_POS:  res = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
      default: res = 32'd0;
    endcase
    return res;
  endfunction

  task automatic clear_command();
    letter_q   = 8'h00;
    key_acc_q  = 32'd0;
    key_ph_q   = qscp_pkg::CV_SKIP;
    val_acc_q  = 32'd0;
    val_ph_q   = qscp_pkg::CV_SKIP;
    val_seen_q = 1'b0;
  endtask

  task automatic reset_parser();
    phase_q = P_WAIT_Q;
    cmds_q  = 7'd0;
    clear_command();
  endtask

  task automatic feed_atoi(inout logic [31:0] acc, inout qscp_pkg::conv_phase_e ph,
                           input logic [7:0] c);
    logic        is_digit;
    logic        take;
    logic [35:0] prod;
    is_digit = (c >= qscp_pkg::ChZero) && (c <= qscp_pkg::ChNine);
    take = 1'b1;
    if (ph == qscp_pkg::CV_DONE) begin
      take = 1'b0;
    end else if (ph == qscp_pkg::CV_SKIP) begin
      if (c == qscp_pkg::ChSpace || (c >= qscp_pkg::ChTab && c <= qscp_pkg::ChCr)) begin
        take = 1'b0;
      end else if (c == qscp_pkg::ChPlus) begin
        ph = qscp_pkg::CV_POS;
        take = 1'b0;
      end else if (c == qscp_pkg::ChMinus) begin
        ph = qscp_pkg::CV_NEG;
        take = 1'b0;
      end else if (!is_digit) begin
        acc = 32'd0;
        ph = qscp_pkg::CV_DONE;
        take = 1'b0;
      end else begin
        ph = qscp_pkg::CV_POS;
      end
    end
    if (take) begin
      if (is_digit) begin
        prod = {4'd0, acc} * 36'd10 + {28'd0, c - qscp_pkg::ChZero};
        acc = (prod > {4'd0, qscp_pkg::MagLimit}) ? qscp_pkg::MagLimit : prod[31:0];
      end else begin
        acc = signed_number(acc, ph);
        ph = qscp_pkg::CV_DONE;
      end
    end
  endtask

  task automatic predict_char(input logic [7:0] c, input logic last);
    logic              finished;
    qscp_pkg::result_t res;
    finished = 1'b0;
    case (phase_q)
      P_WAIT_Q: begin
        if (c == qscp_pkg::ChQuestion) phase_q = P_LETTER;
      end
      P_LETTER: begin
        if (cmds_q >= MaxCommands) begin
          phase_q = P_IGNORE;
          limit_hits++;
        end else begin
          letter_q = c;
          cmds_q = cmds_q + 7'd1;
          phase_q = P_KEY;
        end
      end
      P_KEY: begin
        if (c == qscp_pkg::ChEq) begin
          val_seen_q = 1'b1;
          phase_q = P_VALUE;
        end else if (c == qscp_pkg::ChAmp) begin
          finished = 1'b1;
        end else begin
          feed_atoi(key_acc_q, key_ph_q, c);
        end
      end
      P_VALUE: begin
        if (c == qscp_pkg::ChAmp) finished = 1'b1;
        else feed_atoi(val_acc_q, val_ph_q, c);
      end
      default: ;
    endcase
    if (last && (phase_q == P_KEY || phase_q == P_VALUE)) finished = 1'b1;
    if (finished || last) begin
      res = '0;
      if (finished) begin
        res.cmd_valid   = 1'b1;
        res.letter      = letter_q;
        res.number      = 5'(cmds_q - 7'd1);
        res.key         = signed_number(key_acc_q, key_ph_q);
        res.val_present = val_seen_q;
        res.value       = signed_number(val_acc_q, val_ph_q);
        clear_command();
        phase_q = P_LETTER;
      end
      res.end_of_query = last;
      expected_results.push_back(res);
      if (last) reset_parser();
    end
  endtask

  task automatic append_str(input string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endtask

  task automatic commit_string();
    char_req_t req;
    for (int i = 0; i < text.size(); i++) begin
      req.ch = text[i];
      req.last = (i == text.size() - 1);
      pending_chars.push_back(req);
    end
    text.delete();
    strings_built++;
  endtask

  // Decimal field, all optional: white space, sign, digits, '=' in a value, trailing byte.
  task automatic append_number(input logic in_value);
    logic [7:0] b;
    int         len;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        b = 8'($urandom_range(qscp_pkg::ChTab, qscp_pkg::ChCr + 1));
        text.push_back((b == qscp_pkg::ChCr + 8'd1) ? qscp_pkg::ChSpace : b);
      end
    end
    case ($urandom_range(0, 3))
      0: text.push_back(qscp_pkg::ChPlus);
      1: text.push_back(qscp_pkg::ChMinus);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) begin
      append_str(edge_numbers[$urandom_range(0, 4)]);
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      repeat (len) text.push_back(qscp_pkg::ChZero + 8'($urandom_range(0, 9)));
    end
    if (in_value && $urandom_range(0, 9) == 0) text.push_back(qscp_pkg::ChEq);
    if ($urandom_range(0, 4) == 0) begin
      do b = 8'($urandom_range(0, 255));
      while (b == qscp_pkg::ChAmp || (!in_value && b == qscp_pkg::ChEq));
      text.push_back(b);
    end
  endtask

  task automatic build_query(input int n_cmd, input logic brief);
    logic [7:0] b;
    int         k;
    repeat ($urandom_range(0, 3)) begin
      do b = 8'($urandom_range(0, 255)); while (b == qscp_pkg::ChQuestion);
      text.push_back(b);
    end
    text.push_back(qscp_pkg::ChQuestion);
    for (k = 0; k < n_cmd; k++) begin
      if (k > 0) text.push_back(qscp_pkg::ChAmp);
      text.push_back(8'($urandom_range(0, 255)));
      if (brief) text.push_back(qscp_pkg::ChZero + 8'($urandom_range(0, 9)));
      else append_number(1'b0);
      if ($urandom_range(0, 99) < 60) begin
        text.push_back(qscp_pkg::ChEq);
        if (brief) text.push_back(qscp_pkg::ChZero + 8'($urandom_range(0, 9)));
        else append_number(1'b1);
      end
    end
    if ($urandom_range(0, 9) == 0) text.push_back(qscp_pkg::ChAmp);
  endtask

  function automatic int idle_mode(int n);
    return (n / 160) % 4;
  endfunction

  // Sender: offers queued characters and predicts the results of accepted ones.
  always @(posedge clk_i or negedge rst_ni) begin
    int idle_pct;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_char(s_axis_tdata, s_axis_tlast);
        accepted_cnt <= accepted_cnt + 1;
      end
      case (idle_mode(accepted_cnt))
        1: idle_pct = 57;
        3: idle_pct = 15;
        default: idle_pct = 0;
      endcase
      if (!s_axis_tvalid || s_axis_tready) begin
        if (next_char < pending_chars.size() && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_chars[next_char].ch;
          s_axis_tlast  <= pending_chars[next_char].last;
          next_char++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver so that the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_on    <= 1'b0;
      hold_done  <= 1'b0;
      hold_count <= 0;
    end else if (hold_on) begin
      if (hold_count == HoldCycles - 1) begin
        hold_on   <= 1'b0;
        hold_done <= 1'b1;
      end
      hold_count <= hold_count + 1;
    end else if (!hold_done && accepted_cnt >= HoldStart) begin
      hold_on <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int stall_pct;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode(accepted_cnt))
        2: stall_pct = 57;
        3: stall_pct = 15;
        default: stall_pct = 0;
      endcase
      m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Receiver: checks every accepted result request against the oldest prediction.
  always @(posedge clk_i) begin
    qscp_pkg::result_t got;
    qscp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.cmd_valid    = m_axis_tuser;
      got.letter       = m_axis_tdata[7:0];
      got.number       = m_axis_tdata[12:8];
      got.key          = m_axis_tdata[44:13];
      got.val_present  = m_axis_tdata[45];
      got.value        = m_axis_tdata[77:46];
      got.end_of_query = m_axis_tlast;
      results_seen++;
      if (m_axis_tuser) commands_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result at %0t: valid %b letter %h num %0d key %0d", $realtime,
                   got.cmd_valid, got.letter, got.number, $signed(got.key));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t:", $realtime);
            $display("  expected valid %b letter %h num %0d key %0d vp %b value %0d eoq %b",
                     want.cmd_valid, want.letter, want.number, $signed(want.key),
                     want.val_present, $signed(want.value), want.end_of_query);
            $display("  actual   valid %b letter %h num %0d key %0d vp %b value %0d eoq %b",
                     got.cmd_valid, got.letter, got.number, $signed(got.key),
                     got.val_present, $signed(got.value), got.end_of_query);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles.", CycleLimit);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int kind;
    int n;
    reset_parser();

    // Extreme bytes as letters, an equals sign inside a value, an empty key.
    text.push_back(8'h00);
    append_str("?");
    text.push_back(8'hFF);
    append_str("1==5&");
    text.push_back(8'h00);
    commit_string();
    append_str("?a=");           // empty value at the end of the string
    commit_string();
    append_str("b");             // string without a query part
    commit_string();
    append_str("?");             // string ending right after the question mark
    commit_string();
    append_str("?z \t-7&y+9");   // white space, both signs
    commit_string();

    n = pending_chars.size() + RandomChars;
    while (pending_chars.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        build_query($urandom_range(MaxCommands + 1, MaxCommands + 8), 1'b1);
      end else if (kind < 18) begin
        repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 30) begin
        build_query($urandom_range(1, 6), 1'b0);
        text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end else begin
        build_query($urandom_range(1, 6), 1'b0);
      end
      commit_string();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (next_char < pending_chars.size() || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d characters in %0d strings; checked %0d results, %0d of them commands.",
             pending_chars.size(), strings_built, results_seen, commands_seen);
    $display("%0d strings reached the command limit; the receiver held off once for %0d cycles.",
             limit_hits, HoldCycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
